>>> rtl/corner_point_cell_vertices_top_assert.svh
// Assertion macros shared by the corner-point cell vertex RTL.
`ifndef CORNER_POINT_CELL_VERTICES_TOP_ASSERT_SVH
`define CORNER_POINT_CELL_VERTICES_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CPCV_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define CPCV_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/cpcv_pkg.sv
// Types, constants and helpers of the corner-point cell vertex engine.
package cpcv_pkg;

  localparam int MAX_X_CELLS = 32;
  localparam int MAX_Y_CELLS = 32;
  localparam int MAX_Z_CELLS = 16;
  localparam int CW          = 48;
  localparam int PILLARS     = (MAX_X_CELLS + 1) * (MAX_Y_CELLS + 1);
  localparam int DEPTHS      = 8 * MAX_X_CELLS * MAX_Y_CELLS * MAX_Z_CELLS;
  localparam int PIL_AW      = $clog2(PILLARS);
  localparam int DEP_AW      = $clog2(DEPTHS);
  localparam int DIV_STEPS   = CW + 24;
  localparam int CNT_W       = $clog2(DIV_STEPS);
  localparam int ACC_W       = 64 + CW;

  typedef enum logic [1:0] {
    FUNC_PILLAR = 2'd0,
    FUNC_DEPTH  = 2'd1,
    FUNC_QUERY  = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DEGEN = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CFG_X = 2'd0,
    CFG_Y = 2'd1,
    CFG_Z = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]           func;
    logic [16:0]          store_index;
    logic signed [CW-1:0] top_x;
    logic signed [CW-1:0] top_y;
    logic signed [CW-1:0] top_z;
    logic signed [CW-1:0] bot_x;
    logic signed [CW-1:0] bot_y;
    logic signed [CW-1:0] bot_z;
    logic signed [CW-1:0] depth_value;
    logic [4:0]           cell_i;
    logic [4:0]           cell_j;
    logic [3:0]           cell_k;
  } in_item_t;

  typedef struct packed {
    logic [2:0]           corner;
    logic signed [CW-1:0] vert_x;
    logic signed [CW-1:0] vert_y;
    logic signed [CW-1:0] vert_z;
    logic [1:0]           status;
    logic                 last;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic       wr;
    logic       load;
    logic       addr;
    logic       rd;
    logic       prep;
    logic       div;
    logic       mul;
    logic       fin;
    logic       put_vert;
    logic       put_deg;
    logic       put_err;
    logic [2:0] step;
    logic [2:0] mul_sel;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic range_err;
    logic vert;
    logic deg;
    logic last;
  } sts_t;

  // corner number for each walk step (jp, ip, kp from msb to lsb)
  function automatic logic [2:0] corner_of(input logic [2:0] s);
    logic [2:0] c;
    unique case (s)
      3'd0: c = 3'd0;
      3'd1: c = 3'd4;
      3'd2: c = 3'd1;
      3'd3: c = 3'd5;
      3'd4: c = 3'd3;
      3'd5: c = 3'd7;
      3'd6: c = 3'd2;
      default: c = 3'd6;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/corner_point_cell_vertices_top.sv
// Top level of the corner-point cell vertex engine.
// Usage:
//  - Input channel (in_valid/in_stall/in_data): func 0 writes a pillar, func 1 a
//    corner depth, func 2 queries cell (i,j,k). Writes give no result.
//  - Result channel (out_valid/out_stall/out_data): a query yields its corners in
//    the order 0,4,1,5,3,7,2,6 with last on the final one; a degenerate sloped
//    pillar ends the run with status 1; an out-of-range cell gives one status-2 item.
//  - Config port (cfg_we/cfg_idx/cfg_wdata): x, y, z cell counts, write while idle.
// Timing: one item at a time. A vertical corner shows after the query or the
// previous corner is taken, via the address, read and check states.
// A sloped one also passes through the bit-serial divider and the 32x24
// multiplier that forms both x and y products, then finish. An out-of-range
// cell shows in the cycle after accept.
// in_stall is high from query accept until the final result is taken.
// Receiver stall: the result register holds its item and the sequencer waits.
// Reset (synchronous, rst_n low): sequencer idle, counts back to 32/32/16;
// the stores keep no reset value and must be written before they are queried.
module corner_point_cell_vertices_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  cpcv_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output cpcv_pkg::out_item_t  out_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_idx,
  input  logic [5:0]           cfg_wdata
);
  import cpcv_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: states, corner step and iteration count
  cpcv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_func   (in_data.func),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // stores, arithmetic and result register
  cpcv_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

>>> rtl/cpcv_ctrl.sv
// Sequencer of the corner-point cell vertex engine.
module cpcv_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_func,
  output logic             out_valid,
  input  logic             out_stall,
  input  cpcv_pkg::sts_t   sts,
  output cpcv_pkg::cmd_t   cmd
);
  import cpcv_pkg::*;
  `include "corner_point_cell_vertices_top_assert.svh"

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_ADDR  = 8'b0000_0010,
    S_READ  = 8'b0000_0100,
    S_CHECK = 8'b0000_1000,
    S_DIV   = 8'b0001_0000,
    S_MUL   = 8'b0010_0000,
    S_FIN   = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_t;

  state_t           st_r, st_nxt;
  logic [2:0]       step_r, step_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             acc;

  assign in_stall  = (st_r != S_IDLE);
  assign out_valid = (st_r == S_EMIT);
  assign acc       = in_valid && (st_r == S_IDLE);

  always_comb begin
    st_nxt   = st_r;
    step_nxt = step_r;
    cnt_nxt  = cnt_r;
    cmd      = '0;
    cmd.step    = step_r;
    cmd.mul_sel = cnt_r[2:0];
    unique case (st_r)
      S_IDLE: begin
        if (acc) begin
          priority if (in_func == FUNC_PILLAR || in_func == FUNC_DEPTH) begin
            cmd.wr = 1'b1;
          end else if (in_func == FUNC_QUERY) begin
            if (sts.range_err) begin
              cmd.put_err = 1'b1;
              st_nxt = S_EMIT;
            end else begin
              cmd.load = 1'b1;
              step_nxt = '0;
              st_nxt = S_ADDR;
            end
          end else begin
            st_nxt = S_IDLE;
          end
        end
      end
      S_ADDR: begin
        cmd.addr = 1'b1;
        st_nxt = S_READ;
      end
      S_READ: begin
        cmd.rd = 1'b1;
        st_nxt = S_CHECK;
      end
      S_CHECK: begin
        priority if (sts.vert) begin
          cmd.put_vert = 1'b1;
          st_nxt = S_EMIT;
        end else if (sts.deg) begin
          cmd.put_deg = 1'b1;
          st_nxt = S_EMIT;
        end else begin
          cmd.prep = 1'b1;
          cnt_nxt = '0;
          st_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div = 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          cnt_nxt = '0;
          st_nxt = S_MUL;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        if (cnt_r[2:0] == 3'd7) begin
          cnt_nxt = '0;
          st_nxt = S_FIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        st_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_stall) begin
          if (sts.last) begin
            st_nxt = S_IDLE;
          end else begin
            step_nxt = step_r + 1'b1;
            st_nxt = S_ADDR;
          end
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      step_r <= '0;
      cnt_r  <= '0;
    end else begin
      st_r   <= st_nxt;
      step_r <= step_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  `CPCV_ASSERT_IMP(a_idle_no_out, !in_stall, !out_valid, "result shown while idle")
  `CPCV_ASSERT_NXT(a_last_to_idle, out_valid && !out_stall && sts.last, !in_stall,
                   "not idle after final result")
  `CPCV_ASSERT_NXT(a_div_to_mul, st_r == S_DIV && cnt_r == CNT_W'(DIV_STEPS - 1),
                   st_r == S_MUL, "divider did not hand over to multiplier")
  `CPCV_ASSERT_NXT(a_more_corners, out_valid && !out_stall && !sts.last,
                   st_r == S_ADDR && step_r == $past(step_r) + 3'd1,
                   "corner walk did not advance")

endmodule

>>> rtl/cpcv_dp.sv
// Datapath: stores, address math, serial divider, serial multiplier, output register.
module cpcv_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cpcv_pkg::in_item_t   in_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_idx,
  input  logic [5:0]           cfg_wdata,
  input  cpcv_pkg::cmd_t       cmd,
  output cpcv_pkg::sts_t       sts,
  output cpcv_pkg::out_item_t  out_data
);
  import cpcv_pkg::*;

  localparam logic [CW-1:0] CHALF = {1'b1, {(CW-1){1'b0}}};
  localparam logic [CW-1:0] CMASK = {CW{1'b1}};

  typedef struct packed {
    logic [CW-1:0] tx;
    logic [CW-1:0] ty;
    logic [CW-1:0] tz;
    logic [CW-1:0] bx;
    logic [CW-1:0] by;
    logic [CW-1:0] bz;
  } pillar_t;

  function automatic logic [5:0] clamp_cfg(input logic [5:0] v, input logic [5:0] mx);
    logic [5:0] r;
    if (v == 6'd0) r = 6'd1;
    else if (v > mx) r = mx;
    else r = v;
    return r;
  endfunction

  // saturating negation in offset binary
  function automatic logic [CW-1:0] neg_off(input logic [CW-1:0] u);
    logic [CW-1:0] r;
    if (u == '0) r = CMASK;
    else r = ~u + 1'b1;
    return r;
  endfunction

  // u1 +/- mag, clipped to the coordinate range
  function automatic logic [CW-1:0] blend(input logic [CW-1:0] u1, input logic big,
                                          input logic [CW-1:0] mag, input logic neg);
    logic [CW-1:0] r;
    if (neg) begin
      if (big || mag > u1) r = '0;
      else r = u1 - mag;
    end else begin
      if (big || mag > (CMASK - u1)) r = CMASK;
      else r = u1 + mag;
    end
    return r;
  endfunction

  // configuration
  logic [5:0]  xc_r, yc_r;
  logic [4:0]  zc_r;
  logic [12:0] xy4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xc_r <= 6'(MAX_X_CELLS);
      yc_r <= 6'(MAX_Y_CELLS);
      zc_r <= 5'(MAX_Z_CELLS);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_X:   xc_r <= clamp_cfg(cfg_wdata, 6'(MAX_X_CELLS));
        CFG_Y:   yc_r <= clamp_cfg(cfg_wdata, 6'(MAX_Y_CELLS));
        CFG_Z:   zc_r <= 5'(clamp_cfg({1'b0, cfg_wdata[4:0]}, 6'(MAX_Z_CELLS)));
        default: ;
      endcase
    end
  end

  // cells per layer times four, full 11-bit product
  always_ff @(posedge clk) begin
    xy4_r <= {11'(xc_r) * 11'(yc_r), 2'b00};
  end

  assign sts.range_err = ({1'b0, in_data.cell_i} >= xc_r) ||
                         ({1'b0, in_data.cell_j} >= yc_r) ||
                         ({1'b0, in_data.cell_k} >= zc_r);

  // stores
  pillar_t       pil_mem [PILLARS];
  logic [CW-1:0] dep_mem [DEPTHS];
  pillar_t       pil_rd_r;
  logic [CW-1:0] dep_rd_r;
  logic [PIL_AW-1:0] pi_r;
  logic [DEP_AW-1:0] di_r;

  always_ff @(posedge clk) begin
    if (cmd.wr && in_data.func == FUNC_PILLAR && in_data.store_index < 17'(PILLARS)) begin
      pil_mem[in_data.store_index[PIL_AW-1:0]] <= {in_data.top_x, in_data.top_y, in_data.top_z,
                                                   in_data.bot_x, in_data.bot_y, in_data.bot_z};
    end
    if (cmd.rd) begin
      pil_rd_r <= pil_mem[pi_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr && in_data.func == FUNC_DEPTH) begin
      dep_mem[in_data.store_index[DEP_AW-1:0]] <= in_data.depth_value;
    end
    if (cmd.rd) begin
      dep_rd_r <= dep_mem[di_r];
    end
  end

  // query and addresses
  logic [4:0]  ci_r, cj_r;
  logic [3:0]  ck_r;
  logic        jp, ip, kp;
  logic [5:0]  jrow;
  logic [6:0]  xc1;
  logic [12:0] prow;
  logic [13:0] pfull;
  logic [17:0] dlay;
  logic [12:0] drow;
  logic [18:0] dfull;

  assign jp    = cmd.step[2];
  assign ip    = cmd.step[1];
  assign kp    = cmd.step[0];
  assign jrow  = {1'b0, cj_r} + {5'b0, jp};
  assign xc1   = {1'b0, xc_r} + 7'd1;
  assign prow  = jrow * xc1;
  assign pfull = {1'b0, prow} + {8'b0, ({1'b0, ci_r} + {5'b0, ip})};
  assign dlay  = {ck_r, kp} * xy4_r;
  assign drow  = {cj_r, jp} * {xc_r, 1'b0};
  assign dfull = {1'b0, dlay} + {6'b0, drow} + {13'b0, ci_r, ip};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ci_r <= in_data.cell_i;
      cj_r <= in_data.cell_j;
      ck_r <= in_data.cell_k;
    end
    if (cmd.addr) begin
      pi_r <= (pfull < 14'(PILLARS)) ? pfull[PIL_AW-1:0] : '0;
      di_r <= (dfull < 19'(DEPTHS)) ? dfull[DEP_AW-1:0] : '0;
    end
  end

  // corner evaluation, all in offset binary
  logic [CW-1:0] x1o, y1o, z1o, x2o, y2o, z2o, zo;
  assign x1o = pil_rd_r.tx ^ CHALF;
  assign y1o = pil_rd_r.ty ^ CHALF;
  assign z1o = pil_rd_r.tz ^ CHALF;
  assign x2o = pil_rd_r.bx ^ CHALF;
  assign y2o = pil_rd_r.by ^ CHALF;
  assign z2o = pil_rd_r.bz ^ CHALF;
  assign zo  = dep_rd_r ^ CHALF;

  assign sts.vert = (pil_rd_r.tx == pil_rd_r.bx) && (pil_rd_r.ty == pil_rd_r.by);
  assign sts.deg  = (pil_rd_r.tz == pil_rd_r.bz);

  logic [CW-1:0]        x1_r, y1_r, zo_r, dxm_r, dym_r, dm_r, rem_r;
  logic                 dxn_r, dyn_r, qneg_r;
  logic [DIV_STEPS-1:0] num_r, quo_r;
  logic [ACC_W-1:0]     accx_r, accy_r;

  // divider step
  logic [CW:0]   rem2;
  logic          ge;
  assign rem2 = {rem_r, num_r[DIV_STEPS-1]};
  assign ge   = rem2 >= {1'b0, dm_r};

  // quotient saturates at 2^63-1
  logic [63:0] qm;
  assign qm = (|quo_r[DIV_STEPS-1:63]) ? {1'b0, {63{1'b1}}} : {1'b0, quo_r[62:0]};

  // multiplier step: 32 x 24 partial product, placed by shift
  logic [31:0]      qpart;
  logic [CW/2-1:0]  dpart;
  logic [CW-1:0]    dsrc;
  logic [55:0]      pp;
  logic [ACC_W-1:0] pps;
  assign qpart = cmd.mul_sel[1] ? qm[63:32] : qm[31:0];
  assign dsrc  = cmd.mul_sel[2] ? dym_r : dxm_r;
  assign dpart = cmd.mul_sel[0] ? dsrc[CW-1:CW/2] : dsrc[CW/2-1:0];
  assign pp    = qpart * dpart;

  always_comb begin
    unique case (cmd.mul_sel[1:0])
      2'd0: pps = ACC_W'(pp);
      2'd1: pps = ACC_W'(pp) << (CW/2);
      2'd2: pps = ACC_W'(pp) << 32;
      default: pps = ACC_W'(pp) << (32 + CW/2);
    endcase
  end

  logic [CW-1:0] xfin, yfin;
  assign xfin = blend(x1_r, |accx_r[ACC_W-1:CW+24], accx_r[CW+23:24], qneg_r != dxn_r);
  assign yfin = blend(y1_r, |accy_r[ACC_W-1:CW+24], accy_r[CW+23:24], qneg_r != dyn_r);

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      x1_r   <= x1o;
      y1_r   <= y1o;
      zo_r   <= zo;
      dxn_r  <= x2o < x1o;
      dxm_r  <= (x2o < x1o) ? x1o - x2o : x2o - x1o;
      dyn_r  <= y2o < y1o;
      dym_r  <= (y2o < y1o) ? y1o - y2o : y2o - y1o;
      dm_r   <= (z2o < z1o) ? z1o - z2o : z2o - z1o;
      qneg_r <= (zo < z1o) != (z2o < z1o);
      num_r  <= {((zo < z1o) ? z1o - zo : zo - z1o), 24'b0};
      rem_r  <= '0;
      quo_r  <= '0;
      accx_r <= '0;
      accy_r <= '0;
    end
    if (cmd.div) begin
      rem_r <= ge ? CW'(rem2 - {1'b0, dm_r}) : rem2[CW-1:0];
      quo_r <= {quo_r[DIV_STEPS-2:0], ge};
      num_r <= {num_r[DIV_STEPS-2:0], 1'b0};
    end
    if (cmd.mul) begin
      if (cmd.mul_sel[2]) accy_r <= accy_r + pps;
      else accx_r <= accx_r + pps;
    end
  end

  // output register
  out_item_t out_r;
  assign out_data = out_r;
  assign sts.last = out_r.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r <= '0;
    end else begin
      priority if (cmd.put_err) begin
        out_r <= '{corner: 3'd0, vert_x: '0, vert_y: '0, vert_z: '0,
                   status: ST_RANGE, last: 1'b1};
      end else if (cmd.put_deg) begin
        out_r <= '{corner: corner_of(cmd.step), vert_x: '0, vert_y: '0, vert_z: '0,
                   status: ST_DEGEN, last: 1'b1};
      end else if (cmd.put_vert) begin
        out_r <= '{corner: corner_of(cmd.step), vert_x: x1o ^ CHALF,
                   vert_y: neg_off(y1o) ^ CHALF, vert_z: neg_off(zo) ^ CHALF,
                   status: ST_OK, last: cmd.step == 3'd7};
      end else if (cmd.fin) begin
        out_r <= '{corner: corner_of(cmd.step), vert_x: xfin ^ CHALF,
                   vert_y: neg_off(yfin) ^ CHALF, vert_z: neg_off(zo_r) ^ CHALF,
                   status: ST_OK, last: cmd.step == 3'd7};
      end else begin
        out_r <= out_r;
      end
    end
  end

endmodule
